[hw/rtl/erxaf_pkg.sv]
// types and constants for the ethernet receive address filter and classifier
// no dependencies; imported by ethernet_rx_address_filter_classifier and its testbench
package erxaf_pkg;

	localparam int unsigned HEADER_BYTES = 14;
	localparam int unsigned ADDR_BYTES   = 6;
	localparam int unsigned TYPE_OFFSET  = 12;
	localparam int unsigned COUNT_W      = 12;
	localparam int unsigned LEN_W        = 11;
	localparam int unsigned TYPE_W       = 16;
	localparam int unsigned ADDR_W       = 48;

	localparam logic [TYPE_W-1:0]  TYPE_IPV4     = 16'h0800;
	localparam logic [TYPE_W-1:0]  TYPE_ARP      = 16'h0806;
	localparam logic [7:0]         BCAST_BYTE    = 8'hFF;
	localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 11'd1514;

	// register indexes on the configuration port (byte address / 8)
	localparam logic REG_STATION = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_IPV4        = 3'd0,
		VERDICT_ARP         = 3'd1,
		VERDICT_UNSUPPORTED = 3'd2,
		VERDICT_NOT_OURS    = 3'd3,
		VERDICT_TOO_LONG    = 3'd4,
		VERDICT_TOO_SHORT   = 3'd5
	} verdict_t;

endpackage

[hw/rtl/ethernet_rx_address_filter_classifier.sv]
// ethernet receive destination filter and ethertype classifier, top level
// depends on erxaf_pkg
//
// usage:
//   input channel (in_valid/in_stall, rx_byte, last_byte) takes one frame byte per
//   transaction in wire order; last_byte marks the final byte of a frame.
//   output channel (out_valid/out_stall, verdict, ether_type, payload_length)
//   carries one verdict transaction per frame, produced by the last byte.
//   apb port: register 0 (addr 0x0) station_address, 48 bits, first byte in the
//   top byte; register 1 (addr 0x8) max_frame_length, 11 bits, reset 1514.
//   the user must write registers only while no frame is in flight; the block does not enforce it.
// timing:
//   one byte per cycle sustained while no last byte is held back by a pending
//   verdict. a byte is captured in the input register, then the frame state and
//   (on a last byte) the result register are updated from it; the verdict is
//   valid once the result register is loaded and is taken when out_stall is low.
//   the single result register plus input register decouple the two sides, so
//   non-last bytes keep flowing while a verdict waits to be taken.
// reset: clears the byte counter and captured type, sets both match flags,
//   drops both valid flags; station address reads 0 and max frame length 1514.
// stall: when out_stall holds a pending verdict, non-last bytes still pass;
//   a last byte waits in the input register and in_stall rises until the
//   verdict is taken.
module ethernet_rx_address_filter_classifier
	import erxaf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// byte input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                last_byte,
	// verdict output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          verdict,
	output logic [TYPE_W-1:0]   ether_type,
	output logic [LEN_W-1:0]    payload_length,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [ADDR_W-1:0] station_q;
	logic [LEN_W-1:0]  max_len_q;

	// input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       last_byte_s1;

	// per-frame state
	logic [COUNT_W-1:0] count_q;
	logic               ucast_q;
	logic               bcast_q;
	logic [TYPE_W-1:0]  type_q;

	// result register
	logic              out_valid_q;
	verdict_t          verdict_q;
	logic [TYPE_W-1:0] etype_q;
	logic [LEN_W-1:0]  plen_q;

	logic                cfg_wr;
	logic                in_accept;
	logic                out_free;
	logic                s1_go;
	logic                in_addr;
	logic                in_type;
	logic [7:0]          own_byte;
	logic [COUNT_W-1:0]  count_nxt;
	logic                ucast_nxt;
	logic                bcast_nxt;
	logic [TYPE_W-1:0]   type_nxt;
	verdict_t            verdict_nxt;
	logic [TYPE_W-1:0]   etype_nxt;
	logic [LEN_W-1:0]    plen_nxt;
	logic [COUNT_W-1:0]  plen_full;

	// apb: always ready, index from address bit 3
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3])
			REG_STATION: prdata = {16'd0, station_q};
			REG_MAX_LEN: prdata = {53'd0, max_len_q};
			default:     prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_STATION: station_q <= pwdata[ADDR_W-1:0];
				REG_MAX_LEN: max_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: a last byte needs a free result register to move on
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_go     = valid_s1 && (!last_byte_s1 || out_free);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1   <= rx_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// destination byte of the station address for this position
	always_comb begin
		case (count_q[2:0])
			3'd0:    own_byte = station_q[47:40];
			3'd1:    own_byte = station_q[39:32];
			3'd2:    own_byte = station_q[31:24];
			3'd3:    own_byte = station_q[23:16];
			3'd4:    own_byte = station_q[15:8];
			3'd5:    own_byte = station_q[7:0];
			default: own_byte = 8'd0;
		endcase
	end

	assign in_addr = count_q < COUNT_W'(ADDR_BYTES);
	assign in_type = (count_q == COUNT_W'(TYPE_OFFSET)) ||
	                 (count_q == COUNT_W'(TYPE_OFFSET + 1));

	// frame state after this byte
	assign count_nxt = (&count_q) ? count_q : count_q + 1'b1;
	assign ucast_nxt = ucast_q && !(in_addr && (rx_byte_s1 != own_byte));
	assign bcast_nxt = bcast_q && !(in_addr && (rx_byte_s1 != BCAST_BYTE));
	assign type_nxt  = in_type ? {type_q[7:0], rx_byte_s1} : type_q;
	assign plen_full = count_nxt - COUNT_W'(HEADER_BYTES);

	// verdict priority: too short, not ours, too long, then ethertype
	always_comb begin
		etype_nxt = type_nxt;
		plen_nxt  = '0;
		if (count_nxt < COUNT_W'(HEADER_BYTES)) begin
			verdict_nxt = VERDICT_TOO_SHORT;
			etype_nxt   = '0;
		end else if (!ucast_nxt && !bcast_nxt) begin
			verdict_nxt = VERDICT_NOT_OURS;
		end else if (count_nxt > {1'b0, max_len_q}) begin
			verdict_nxt = VERDICT_TOO_LONG;
		end else if (type_nxt == TYPE_IPV4) begin
			verdict_nxt = VERDICT_IPV4;
			plen_nxt    = plen_full[LEN_W-1:0];
		end else if (type_nxt == TYPE_ARP) begin
			verdict_nxt = VERDICT_ARP;
			plen_nxt    = plen_full[LEN_W-1:0];
		end else begin
			verdict_nxt = VERDICT_UNSUPPORTED;
		end
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ucast_q <= 1'b1;
			bcast_q <= 1'b1;
			type_q  <= '0;
		end else if (s1_go) begin
			if (last_byte_s1) begin
				count_q <= '0;
				ucast_q <= 1'b1;
				bcast_q <= 1'b1;
				type_q  <= '0;
			end else begin
				count_q <= count_nxt;
				ucast_q <= ucast_nxt;
				bcast_q <= bcast_nxt;
				type_q  <= type_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_byte_s1) begin
			verdict_q <= verdict_nxt;
			etype_q   <= etype_nxt;
			plen_q    <= plen_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign ether_type     = etype_q;
	assign payload_length = plen_q;

	// checks
	a_short_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == VERDICT_TOO_SHORT) |-> (etype_q == '0 && plen_q == '0))
		else $error("too short verdict carries type or length");

	a_ipv4_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == VERDICT_IPV4) |-> (etype_q == TYPE_IPV4))
		else $error("ipv4 verdict with other ethertype");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_byte_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked last byte");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_byte_s1) |=> (count_q == '0 && ucast_q && bcast_q && type_q == '0))
		else $error("frame state not cleared after last byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(verdict_q) && $stable(plen_q)))
		else $error("pending verdict overwritten");

endmodule

[bench/tb_ethernet_rx_address_filter_classifier.sv]
// testbench for ethernet_rx_address_filter_classifier: directed and random frames byte by byte,
// a scoreboard class predicts each verdict and checks the output channel in order
// depends on erxaf_pkg and the ethernet_rx_address_filter_classifier rtl
module tb_ethernet_rx_address_filter_classifier;
	import erxaf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int          RANDOM_BYTES  = 1450;
	localparam int          RANDOM_PHASES = 8;
	localparam int          REPORT_MAX    = 10;

	// one expected verdict transaction
	typedef struct packed {
		verdict_t          verdict;
		logic [TYPE_W-1:0] ether_type;
		logic [LEN_W-1:0]  payload_length;
	} frame_verdict_t;

	// how the destination address of a generated frame is formed
	typedef enum int {DEST_OWN, DEST_BCAST, DEST_NEAR, DEST_OTHER} dest_kind_e;

	// handshake pressure for a phase
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	// tracks the frame in progress exactly as the filter does and holds the
	// verdicts that are still owed by the block, oldest first
	class frame_verdict_scoreboard;
		logic [ADDR_W-1:0]  station;
		logic [LEN_W-1:0]   max_len;
		logic [COUNT_W-1:0] byte_count;
		bit                 unicast_hit;
		bit                 bcast_hit;
		logic [TYPE_W-1:0]  type_sr;
		frame_verdict_t     pending_verdicts[$];
		int                 mismatches;
		int                 bytes_seen;
		int                 verdicts_checked;
		int                 kind_count[6];

		function new();
			station          = '0;
			max_len          = MAX_LEN_RESET;
			mismatches       = 0;
			bytes_seen       = 0;
			verdicts_checked = 0;
			foreach (kind_count[i])
				kind_count[i] = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_count  = '0;
			unicast_hit = 1'b1;
			bcast_hit   = 1'b1;
			type_sr     = '0;
		endfunction

		// an accepted byte transaction; a last byte yields one expected verdict
		function void note_byte(logic [7:0] b, logic is_last);
			int unsigned        idx;
			logic [7:0]         own;
			logic [COUNT_W-1:0] len;
			frame_verdict_t     v;
			idx = byte_count;
			bytes_seen++;
			// destination bytes: compare against own address and broadcast
			if (idx < ADDR_BYTES) begin
				own = 8'(station >> (8 * (ADDR_BYTES - 1 - idx)));
				if (b != own)
					unicast_hit = 1'b0;
				if (b != BCAST_BYTE)
					bcast_hit = 1'b0;
			end
			// ethertype is big endian at bytes 12 and 13
			if (idx == TYPE_OFFSET || idx == TYPE_OFFSET + 1)
				type_sr = {type_sr[7:0], b};
			// the count sticks at all ones on very long frames
			if (byte_count != '1)
				byte_count++;
			if (!is_last)
				return;
			len              = byte_count;
			v.ether_type     = type_sr;
			v.payload_length = '0;
			// priority: too short, not ours, too long, then the type decision
			if (len < HEADER_BYTES) begin
				v.verdict    = VERDICT_TOO_SHORT;
				v.ether_type = '0;
			end else if (!unicast_hit && !bcast_hit) begin
				v.verdict = VERDICT_NOT_OURS;
			end else if (len > max_len) begin
				v.verdict = VERDICT_TOO_LONG;
			end else if (type_sr == TYPE_IPV4) begin
				v.verdict        = VERDICT_IPV4;
				v.payload_length = LEN_W'(len - HEADER_BYTES);
			end else if (type_sr == TYPE_ARP) begin
				v.verdict        = VERDICT_ARP;
				v.payload_length = LEN_W'(len - HEADER_BYTES);
			end else begin
				v.verdict = VERDICT_UNSUPPORTED;
			end
			kind_count[v.verdict]++;
			pending_verdicts.push_back(v);
			clear_frame();
		endfunction

		// an accepted verdict transaction against the oldest prediction
		function void check_verdict(logic [2:0] v, logic [TYPE_W-1:0] et, logic [LEN_W-1:0] pl);
			frame_verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected verdict %0d type %h length %0d, no frame pending",
						v, et, pl);
				return;
			end
			exp_v = pending_verdicts.pop_front();
			verdicts_checked++;
			if (v !== exp_v.verdict || et !== exp_v.ether_type
					|| pl !== exp_v.payload_length) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("frame %0d: expected verdict %0d type %h length %0d, got %0d %h %0d",
						verdicts_checked, exp_v.verdict, exp_v.ether_type,
						exp_v.payload_length, v, et, pl);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [7:0]          rx_byte   = '0;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          verdict;
	logic [TYPE_W-1:0]   ether_type;
	logic [LEN_W-1:0]    payload_length;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [3:0]          paddr     = '0;
	logic [63:0]         pwdata    = '0;
	logic [63:0]         prdata;
	logic                pready;

	// per cent chance of an idle cycle on each side, set per phase
	int                  send_pct       = 0;
	int                  stall_pct      = 0;
	int                  settings_count = 1;
	int unsigned         cycle_count    = 0;

	frame_verdict_scoreboard sb = new();

	ethernet_rx_address_filter_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.ether_type     (ether_type),
		.payload_length (payload_length),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output side: check the transaction taken at this edge, then pick the
	// stall for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(verdict, ether_type, payload_length);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// one byte transaction; valid stays up afterwards so back-to-back bytes
	// never see valid dropped and raised in the same step
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		rx_byte   <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, is_last);
	endtask

	// build a frame of len bytes and send it; bytes past the header are random
	task automatic send_frame(input dest_kind_e kind, input logic [TYPE_W-1:0] et,
			input int len);
		logic [ADDR_W-1:0] dest;
		logic [7:0]        b;
		int                k;
		case (kind)
			DEST_OWN: begin
				dest = sb.station;
			end
			DEST_BCAST: begin
				dest = '1;
			end
			DEST_NEAR: begin
				// own address with a single byte spoiled
				dest = sb.station;
				k = $urandom_range(ADDR_BYTES - 1);
				dest[8*k +: 8] = dest[8*k +: 8] ^ 8'($urandom_range(1, 255));
			end
			default: begin
				dest = ADDR_W'({$urandom, $urandom});
			end
		endcase
		for (int i = 0; i < len; i++) begin
			if (i < ADDR_BYTES)
				b = dest[8*(ADDR_BYTES-1-i) +: 8];
			else if (i == TYPE_OFFSET)
				b = et[15:8];
			else if (i == TYPE_OFFSET + 1)
				b = et[7:0];
			else
				b = 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	// mostly well formed frames with random content; the rest are near misses
	// on address and type, runts, and frames around the length limit
	task automatic random_frame(output int len);
		int                r;
		int                m;
		dest_kind_e        kind;
		logic [TYPE_W-1:0] et;
		r = $urandom_range(99);
		kind = r < 45 ? DEST_OWN : r < 70 ? DEST_BCAST : r < 85 ? DEST_NEAR : DEST_OTHER;
		r = $urandom_range(99);
		if (r < 40)
			et = TYPE_IPV4;
		else if (r < 70)
			et = TYPE_ARP;
		else if (r < 80)
			et = TYPE_IPV4 ^ (16'h1 << $urandom_range(TYPE_W - 1));
		else if (r < 88)
			et = TYPE_ARP ^ (16'h1 << $urandom_range(TYPE_W - 1));
		else
			et = TYPE_W'($urandom);
		m = sb.max_len;
		r = $urandom_range(99);
		if (r < 10)
			len = $urandom_range(1, HEADER_BYTES - 1);
		else if (r < 30 && m >= 2 && m <= 200)
			len = $urandom_range(m - 1, m + 1);
		else
			len = $urandom_range(HEADER_BYTES, 48);
		send_frame(kind, et, len);
	endtask

	// stop sending and wait for every owed verdict
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic index, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_STATION)
			sb.station = data[ADDR_W-1:0];
		else
			sb.max_len = data[LEN_W-1:0];
		@(posedge clk);
	endtask

	// new register values only between frames, with the pipe empty
	task automatic apply_settings(input logic [ADDR_W-1:0] st, input logic [LEN_W-1:0] ml);
		drain_verdicts();
		// a non-last byte can still sit in the input stage; give it time
		repeat (4) @(posedge clk);
		write_reg(REG_STATION, 64'(st));
		write_reg(REG_MAX_LEN, 64'(ml));
		settings_count++;
	endtask

	initial begin
		int                phase_bytes;
		int                flen;
		logic [ADDR_W-1:0] st;
		logic [LEN_W-1:0]  ml;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset values: station 0, max length 1514
		send_frame(DEST_BCAST, TYPE_IPV4, 1);             // single byte runt
		send_frame(DEST_OWN, TYPE_IPV4, HEADER_BYTES - 1); // one short of a header
		send_frame(DEST_OTHER, TYPE_ARP, 5);              // runt beats not ours
		send_frame(DEST_BCAST, TYPE_IPV4, HEADER_BYTES);  // empty ipv4 payload
		send_frame(DEST_OWN, TYPE_ARP, HEADER_BYTES);
		send_frame(DEST_OWN, 16'hFFFF, 20);               // unsupported types
		send_frame(DEST_OWN, 16'h0000, 20);
		send_frame(DEST_OTHER, TYPE_IPV4, 20);            // not addressed here
		send_frame(DEST_NEAR, TYPE_IPV4, 16);

		// random phases, each with its own settings and handshake pressure
		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			st = ADDR_W'({$urandom, $urandom});
			case (p)
				1: ml = '1;
				2: begin
					st = '1;   // own address equals broadcast
					ml = HEADER_BYTES;
				end
				3: begin
					st = '0;
					ml = '0;   // every addressed frame of header length or more is too long
				end
				4: ml = 60;
				5: ml = $urandom_range(HEADER_BYTES, 100);
				6: ml = MAX_LEN_RESET;
				7: ml = $urandom_range(HEADER_BYTES + 1, 80);
				default: ml = 30;
			endcase
			apply_settings(st, ml);
			case (idle_mode_e'((p - 1) % 4))
				IDLE_NONE: begin
					send_pct  = 0;
					stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_pct  = 78;
					stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_pct  = 0;
					stall_pct = 78;
				end
				default: begin
					send_pct  = 9;
					stall_pct = 9;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < RANDOM_BYTES / RANDOM_PHASES) begin
				// now and then hold off until the output side has caught up
				if ($urandom_range(99) < 6)
					drain_verdicts();
				random_frame(flen);
				phase_bytes += flen;
			end
		end

		drain_verdicts();
		repeat (8) @(posedge clk);
		$display("tb: %0d bytes, %0d verdicts checked, %0d register settings",
			sb.bytes_seen, sb.verdicts_checked, settings_count);
		$display("tb: ipv4 %0d arp %0d unsupported %0d not ours %0d too long %0d too short %0d",
			sb.kind_count[VERDICT_IPV4], sb.kind_count[VERDICT_ARP],
			sb.kind_count[VERDICT_UNSUPPORTED], sb.kind_count[VERDICT_NOT_OURS],
			sb.kind_count[VERDICT_TOO_LONG], sb.kind_count[VERDICT_TOO_SHORT]);
		if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
